// ===== src/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    localparam int unsigned DistW   = 16;
    localparam int unsigned CountW  = 16;
    localparam int unsigned PulseW  = 17;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgDatW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_TRIGGER_TICKS = 2'd0,
        REG_RISE_TIMEOUT  = 2'd1,
        REG_MAX_OVERFLOWS = 2'd2,
        REG_CM_PER_TICK   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ECHO  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  trigger_ticks;
        logic [15:0] rise_timeout_ticks;
        logic [7:0]  max_overflows;
        logic [15:0] cm_per_tick_q16;
    } t_cfg;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        t_status           status;
        logic [DistW-1:0]  distance_cm;
    } t_result;

endpackage

// ===== src/uer_core.sv =====
// Measurement sequencer: phase state, tick counters and distance scaling.
module uer_core
    import uer_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_kind,
    input  logic    i_echo_level,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase              r_phase,     n_phase;
    logic [CountW-1:0]   r_phase_cnt, n_phase_cnt;
    logic [PulseW-1:0]   r_pulse,     n_pulse;

    logic [CountW-1:0]   cnt_inc;
    logic [PulseW-1:0]   pulse_inc;
    logic [PulseW-1:0]   pulse_limit;
    logic [32:0]         prod;
    logic [16:0]         dist_wide;
    logic [DistW-1:0]    dist_sat;

    assign cnt_inc     = r_phase_cnt + 16'd1;
    assign pulse_inc   = r_pulse + 17'd1;
    // (max_overflows + 1) * 256
    assign pulse_limit = {({1'b0, i_cfg.max_overflows} + 9'd1), 8'h00};
    assign prod        = {16'b0, r_pulse} * {17'b0, i_cfg.cm_per_tick_q16};
    assign dist_wide   = prod[32:16];
    assign dist_sat    = dist_wide[16] ? {DistW{1'b1}} : dist_wide[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_phase_cnt <= '0;
            r_pulse     <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_phase_cnt <= n_phase_cnt;
            r_pulse     <= n_pulse;
        end
    end

    always_comb begin
        t_result res;
        res         = '0;
        res.status  = ST_OK;
        n_phase     = r_phase;
        n_phase_cnt = r_phase_cnt;
        n_pulse     = r_pulse;

        if (i_kind) begin
            if (r_phase == PH_IDLE) begin
                n_phase           = PH_TRIG;
                n_phase_cnt       = '0;
                n_pulse           = '0;
                res.trigger_level = 1'b1;
            end else begin
                res.trigger_level = (r_phase == PH_TRIG);
            end
        end else begin
            unique case (r_phase)
                PH_TRIG: begin
                    res.trigger_level = 1'b1;
                    n_phase_cnt       = cnt_inc;
                    if (cnt_inc >= {8'b0, i_cfg.trigger_ticks}) begin
                        n_phase     = PH_WAIT;
                        n_phase_cnt = '0;
                    end
                end
                PH_WAIT: begin
                    if (i_echo_level) begin
                        // first high tick already counts as pulse time
                        n_phase     = PH_MEAS;
                        n_phase_cnt = '0;
                        n_pulse     = 17'd1;
                    end else begin
                        n_phase_cnt = cnt_inc;
                        if (cnt_inc >= i_cfg.rise_timeout_ticks) begin
                            n_phase      = PH_IDLE;
                            n_phase_cnt  = '0;
                            res.done_res = 1'b1;
                            res.status   = ST_NO_ECHO;
                        end
                    end
                end
                PH_MEAS: begin
                    if (i_echo_level) begin
                        n_pulse = pulse_inc;
                        if (pulse_inc >= pulse_limit) begin
                            n_phase      = PH_IDLE;
                            n_pulse      = '0;
                            res.done_res = 1'b1;
                            res.status   = ST_TOO_LONG;
                        end
                    end else begin
                        n_phase         = PH_IDLE;
                        n_pulse         = '0;
                        res.done_res    = 1'b1;
                        res.distance_cm = dist_sat;
                    end
                end
                default: begin
                end
            endcase
        end

        res.busy_res = (n_phase != PH_IDLE);
        o_result     = res;
    end

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger: config registers, sequencer, output stage.
//
//  channel  direction  handshake               payload
//  in       to block   i_in_valid/o_in_ready   i_kind, i_echo_level
//  out      from block o_out_valid/i_out_ready o_trigger_level, o_busy_res, o_done_res,
//                                              o_status, o_distance_cm
//  cfg      to block   i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per clock while o_in_ready is high; its result is written to the output register.
// The sequencer state and the 17x16 distance multiply sit before that register.
// A skid register holds one result while the output is stalled, so o_in_ready
// is a flop and drops only after two unread results.
// Synchronous active-low reset: idle phase, config back to defaults, no results.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_kind,
    input  logic                i_echo_level,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_trigger_level,
    output logic                o_busy_res,
    output logic                o_done_res,
    output logic [1:0]          o_status,
    output logic [DistW-1:0]    o_distance_cm,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDatW-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_accept;
    logic    out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid;
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_ticks      <= 8'd3;
            r_cfg.rise_timeout_ticks <= 16'd40000;
            r_cfg.max_overflows      <= 8'd250;
            r_cfg.cm_per_tick_q16    <= 16'd4496;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_TRIGGER_TICKS: r_cfg.trigger_ticks      <= i_cfg_data[7:0];
                REG_RISE_TIMEOUT:  r_cfg.rise_timeout_ticks <= i_cfg_data;
                REG_MAX_OVERFLOWS: r_cfg.max_overflows      <= i_cfg_data[7:0];
                REG_CM_PER_TICK:   r_cfg.cm_per_tick_q16    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    uer_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (in_accept),
        .i_kind       (i_kind),
        .i_echo_level (i_echo_level),
        .i_cfg        (r_cfg),
        .o_result     (core_res)
    );

    // output register + skid: valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept) begin
                r_out <= core_res;
            end
        end else if (in_accept) begin
            r_skid <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trigger_level = r_out.trigger_level;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_status        = r_out.status;
    assign o_distance_cm   = r_out.distance_cm;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.done_res) |-> !r_out.busy_res)
        else $error("measurement ended but still busy");

    a_quiet_unless_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |->
            (r_out.status == ST_OK && r_out.distance_cm == '0))
        else $error("status or distance set without done");

    a_error_no_distance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.distance_cm == '0))
        else $error("distance reported on an error result");

    a_stall_keeps_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_out_ready) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid result lost during output stall");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the ultrasonic echo ranger: predicted readings against DUT output.
module tb_top;
    import uer_pkg::*;

    localparam bit KIND_TICK    = 1'b0;
    localparam bit KIND_START   = 1'b1;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 200;

    // Tracks the ranger sequencer and queues the reading each request should produce.
    class ranging_model;
        t_cfg              cfg;
        t_phase            phase;
        logic [CountW-1:0] phase_ticks;
        logic [PulseW-1:0] echo_ticks;
        t_result           pending_readings[$];
        int                errors;
        int                requests;
        int                readings;
        int                n_ok;
        int                n_no_echo;
        int                n_too_long;

        function new();
            cfg.trigger_ticks      = 8'd3;
            cfg.rise_timeout_ticks = 16'd40000;
            cfg.max_overflows      = 8'd250;
            cfg.cm_per_tick_q16    = 16'd4496;
            phase       = PH_IDLE;
            phase_ticks = '0;
            echo_ticks  = '0;
            errors      = 0;
            requests    = 0;
            readings    = 0;
            n_ok        = 0;
            n_no_echo   = 0;
            n_too_long  = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CfgDatW-1:0] data);
            case (idx)
                REG_TRIGGER_TICKS: cfg.trigger_ticks      = data[7:0];
                REG_RISE_TIMEOUT:  cfg.rise_timeout_ticks = data;
                REG_MAX_OVERFLOWS: cfg.max_overflows      = data[7:0];
                REG_CM_PER_TICK:   cfg.cm_per_tick_q16    = data;
                default: ;
            endcase
        endfunction

        // Returns 0 when the block just ignores the request.
        function bit take_request(logic kind, logic echo);
            t_result           r;
            logic [CountW-1:0] span;
            logic [PulseW-1:0] cap;
            logic [32:0]       prod;
            bit                effective;
            r         = '0;
            effective = 1'b1;
            if (kind == KIND_START) begin
                if (phase == PH_IDLE) begin
                    phase           = PH_TRIG;
                    phase_ticks     = '0;
                    echo_ticks      = '0;
                    r.trigger_level = 1'b1;
                end else begin
                    r.trigger_level = (phase == PH_TRIG);
                    effective       = 1'b0;
                end
            end else begin
                case (phase)
                    PH_TRIG: begin
                        phase_ticks = phase_ticks + 1'b1;
                        span = (cfg.trigger_ticks == 0) ? 16'd1 : 16'(cfg.trigger_ticks);
                        if (phase_ticks >= span) begin
                            phase       = PH_WAIT;
                            phase_ticks = '0;
                        end
                        r.trigger_level = 1'b1;
                    end
                    PH_WAIT: begin
                        if (echo) begin
                            phase       = PH_MEAS;
                            phase_ticks = '0;
                            echo_ticks  = 17'd1;
                        end else begin
                            phase_ticks = phase_ticks + 1'b1;
                            span = (cfg.rise_timeout_ticks == 0) ? 16'd1 : cfg.rise_timeout_ticks;
                            if (phase_ticks >= span) begin
                                phase       = PH_IDLE;
                                phase_ticks = '0;
                                r.done_res  = 1'b1;
                                r.status    = ST_NO_ECHO;
                            end
                        end
                    end
                    PH_MEAS: begin
                        if (echo) begin
                            cap = ({{(PulseW-8){1'b0}}, cfg.max_overflows} + 1'b1) << 8;
                            echo_ticks = echo_ticks + 1'b1;
                            if (echo_ticks >= cap) begin
                                phase      = PH_IDLE;
                                echo_ticks = '0;
                                r.done_res = 1'b1;
                                r.status   = ST_TOO_LONG;
                            end
                        end else begin
                            // Q0.16 factor: keep the integer part, clamp to 16 bits
                            prod = echo_ticks * cfg.cm_per_tick_q16;
                            r.distance_cm = (prod[32:16] > 17'h0FFFF) ? 16'hFFFF : prod[31:16];
                            phase      = PH_IDLE;
                            echo_ticks = '0;
                            r.done_res = 1'b1;
                            r.status   = ST_OK;
                        end
                    end
                    default: effective = 1'b0;
                endcase
            end
            r.busy_res = (phase != PH_IDLE);
            pending_readings.push_back(r);
            requests++;
            return effective;
        endfunction

        task flag_mismatch(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task match_reading(t_result got);
            t_result want;
            if (pending_readings.size() == 0) begin
                flag_mismatch($sformatf("reading with no request outstanding: %h", got));
                return;
            end
            want = pending_readings.pop_front();
            readings++;
            if (got.trigger_level !== want.trigger_level)
                flag_mismatch($sformatf("reading %0d trigger %b, want %b",
                                        readings, got.trigger_level, want.trigger_level));
            if (got.busy_res !== want.busy_res)
                flag_mismatch($sformatf("reading %0d busy %b, want %b",
                                        readings, got.busy_res, want.busy_res));
            if (got.done_res !== want.done_res)
                flag_mismatch($sformatf("reading %0d done %b, want %b",
                                        readings, got.done_res, want.done_res));
            if (got.status !== want.status)
                flag_mismatch($sformatf("reading %0d status %0d, want %0d",
                                        readings, got.status, want.status));
            if (got.distance_cm !== want.distance_cm)
                flag_mismatch($sformatf("reading %0d distance %0d, want %0d",
                                        readings, got.distance_cm, want.distance_cm));
            if (want.done_res) begin
                case (want.status)
                    ST_OK:       n_ok++;
                    ST_NO_ECHO:  n_no_echo++;
                    ST_TOO_LONG: n_too_long++;
                    default: ;
                endcase
            end
        endtask
    endclass

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_ready;
    logic                i_kind       = 1'b0;
    logic                i_echo_level = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready  = 1'b0;
    logic                o_trigger_level;
    logic                o_busy_res;
    logic                o_done_res;
    logic [1:0]          o_status;
    logic [DistW-1:0]    o_distance_cm;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index  = '0;
    logic [CfgDatW-1:0]  i_cfg_data   = '0;

    ranging_model book;
    bit           calm;
    int           effective_items;

    ultrasonic_echo_ranger i_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Leaves valid high afterwards so back-to-back requests need no extra edge.
    task automatic send_item(input logic kind, input logic echo);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_echo_level <= echo;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        if (book.take_request(kind, echo)) effective_items++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CfgDatW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        book.set_reg(idx, data);
    endtask

    // Stop sending, let every outstanding reading come back, then a short hold-off.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Output back-pressure: mostly ready, short stalls, now and then a long one.
    initial begin
        int roll;
        int span;
        forever begin
            @(posedge i_clk);
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                i_out_ready <= 1'b1;
                span = $urandom_range(1, 40);
            end else if (roll < 95) begin
                i_out_ready <= 1'b0;
                span = $urandom_range(1, 4);
            end else begin
                i_out_ready <= 1'b0;
                span = $urandom_range(10, 60);
            end
            repeat (span - 1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            book.match_reading(t_result'({o_trigger_level, o_busy_res, o_done_res,
                                          o_status, o_distance_cm}));
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int                  roll;
        int                  pick;
        int                  trig_n;
        int                  tmo;
        int                  lim;
        int                  wait_n;
        int                  high_n;
        t_reg_idx            idx;
        logic [CfgDatW-1:0]  data;
        book = new();
        calm = 1'b0;
        effective_items = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: idle ticks, starts while busy, echo inside the trigger
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_START, 1'b1);
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b1);
        send_item(KIND_START, 1'b1);
        repeat (2) send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);

        // Zero registers behave as their minimum; upper data bits of byte registers dropped
        drain();
        write_reg(REG_TRIGGER_TICKS, 16'hA500);
        write_reg(REG_RISE_TIMEOUT, 16'h0000);
        write_reg(REG_MAX_OVERFLOWS, 16'h5A00);
        write_reg(REG_CM_PER_TICK, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_TICK, 1'b0);
        send_item(KIND_START, 1'b1);
        send_item(KIND_TICK, 1'b1);
        repeat (3) send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);
        // 256-tick pulse limit: reaching it
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b0);
        repeat (256) send_item(KIND_TICK, 1'b1);

        // Full-scale rise timeout and wrap count: a short pulse well inside both limits
        drain();
        write_reg(REG_RISE_TIMEOUT, 16'hFFFF);
        write_reg(REG_MAX_OVERFLOWS, 16'h00FF);
        i_cfg_valid <= 1'b0;
        send_item(KIND_START, 1'b0);
        send_item(KIND_TICK, 1'b1);
        repeat (20) send_item(KIND_TICK, 1'b0);
        repeat (40) send_item(KIND_TICK, 1'b1);
        send_item(KIND_TICK, 1'b0);

        effective_items = 0;
        while (effective_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                drain();
                repeat ($urandom_range(1, 4)) begin
                    idx  = t_reg_idx'($urandom_range(0, 3));
                    data = 16'($urandom_range(0, 65535));
                    pick = $urandom_range(0, 99);
                    case (idx)
                        REG_TRIGGER_TICKS:
                            data[7:0] = (pick < 8) ? 8'd0 : (pick < 10) ? 8'd255 :
                                        8'($urandom_range(1, 6));
                        REG_RISE_TIMEOUT:
                            data = (pick < 10) ? 16'd0 : (pick < 14) ? 16'hFFFF :
                                   16'($urandom_range(1, 40));
                        REG_MAX_OVERFLOWS:
                            data[7:0] = (pick < 30) ? 8'd0 : (pick < 34) ? 8'd255 :
                                        8'($urandom_range(1, 3));
                        REG_CM_PER_TICK:
                            if (pick < 8) data = 16'd0;
                            else if (pick < 16) data = 16'hFFFF;
                        default: ;
                    endcase
                    write_reg(idx, data);
                end
                i_cfg_valid <= 1'b0;
            end else if (roll < 20) begin
                drain();
            end else if (roll < 28) begin
                // stray requests: idle ticks, starts, partial measurements
                repeat ($urandom_range(1, 6))
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end

            calm   = ($urandom_range(0, 3) == 0);
            trig_n = (book.cfg.trigger_ticks == 0) ? 1 : int'(book.cfg.trigger_ticks);
            tmo    = (book.cfg.rise_timeout_ticks == 0) ? 1 :
                     int'(book.cfg.rise_timeout_ticks);
            lim    = (int'(book.cfg.max_overflows) + 1) * 256;
            pick   = $urandom_range(0, 99);
            if (pick < 15 && tmo <= 64)
                wait_n = tmo;
            else if (pick < 25 && tmo <= 64)
                wait_n = tmo - 1;
            else
                wait_n = $urandom_range(0, (tmo - 1 < 8) ? tmo - 1 : 8);

            send_item(KIND_START, 1'($urandom_range(0, 1)));
            repeat (trig_n) send_item(KIND_TICK, 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 6) == 0) send_item(KIND_START, 1'($urandom_range(0, 1)));
            repeat (wait_n) send_item(KIND_TICK, 1'b0);
            if (wait_n < tmo) begin
                if ($urandom_range(0, 99) < 5 && lim == 256)
                    high_n = 255 + $urandom_range(0, 1);
                else
                    high_n = $urandom_range(1, 12);
                repeat (high_n) send_item(KIND_TICK, 1'b1);
                if (high_n < lim) send_item(KIND_TICK, 1'b0);
            end
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (book.pending_readings.size() != 0)
            book.flag_mismatch($sformatf("%0d readings never arrived",
                                         book.pending_readings.size()));
        $display("ranger run: %0d requests, %0d readings (%0d ranged, %0d no echo, %0d too long)",
                 book.requests, book.readings, book.n_ok, book.n_no_echo, book.n_too_long);
        $display("registers swept through zero, reset and full-scale values; %0d mismatches",
                 book.errors);
        if (book.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== ultrasonic_echo_ranger.f =====
src/uer_pkg.sv
src/uer_core.sv
src/ultrasonic_echo_ranger.sv
dv/tb_top.sv
